@@ rtl/sha1_message_digest_macros.svh @@
// ============================================================================
// SHA-1 message digest assertion macros
// Clocked assertion helpers used by the controller; empty in synthesis.
// ============================================================================
`ifndef SHA1_MESSAGE_DIGEST_MACROS_SVH
`define SHA1_MESSAGE_DIGEST_MACROS_SVH

`ifndef SYNTHESIS
// check while out of reset
`define SHA1MD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// check on every edge, reset included
`define SHA1MD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define SHA1MD_ASSERT(label, prop, msg)
`define SHA1MD_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

@@ rtl/sha1md_pkg.sv @@
// ============================================================================
// SHA-1 message digest package
// Shared constants, command types and round helpers.
// ============================================================================
package sha1md_pkg;

    localparam int NUM_ROUNDS   = 80;
    localparam int DIGEST_WORDS = 5;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] IV_WORDS [DIGEST_WORDS] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    typedef enum logic [1:0] {
        BSEL_DATA,
        BSEL_PAD,
        BSEL_ZERO,
        BSEL_LEN
    } t_byte_sel;

    typedef struct packed {
        logic      shift_byte;
        t_byte_sel byte_sel;
        logic [2:0] len_idx;
        logic      count_inc;
        logic      load_work;
        logic      round_en;
        logic      sched_msg;
        logic [1:0] round_grp;
        logic      add_chain;
        logic      load_iv;
        logic [2:0] word_idx;
    } t_dp_cmd;

    function automatic logic [31:0] round_k(input logic [1:0] grp);
        logic [31:0] k;
        case (grp)
            2'd0:    k = 32'h5a827999;
            2'd1:    k = 32'h6ed9eba1;
            2'd2:    k = 32'h8f1bbcdc;
            default: k = 32'hca62c1d6;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] round_f(input logic [1:0] grp, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        case (grp)
            2'd0:    f = (b & c) | (~b & d);
            2'd2:    f = (b & c) | (b & d) | (c & d);
            default: f = b ^ c ^ d;
        endcase
        return f;
    endfunction

endpackage

@@ rtl/sha1md_datapath.sv @@
// ============================================================================
// SHA-1 datapath
// Message/schedule shift window, round registers, chaining value, length.
// ============================================================================
module sha1md_datapath #(
    parameter int LENGTH_COUNTER_BITS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sha1md_pkg::t_dp_cmd i_cmd,
    input  logic [7:0]         i_data_byte,
    output logic [31:0]        o_digest_word
);
    import sha1md_pkg::*;

    localparam int CNT_W = LENGTH_COUNTER_BITS - 3;

    logic [31:0]      r_win   [16];
    logic [31:0]      r_work  [DIGEST_WORDS];
    logic [31:0]      r_chain [DIGEST_WORDS];
    logic [CNT_W-1:0] r_count;

    logic [63:0]      len_bits;
    logic [7:0][7:0]  len_bytes;
    logic [7:0]       shift_in;
    logic [31:0]      w_exp;
    logic [31:0]      w_new;
    logic [31:0]      f_val;
    logic [31:0]      tmp;

    assign len_bits  = 64'({r_count, 3'b000});
    assign len_bytes = len_bits;

    always_comb begin
        case (i_cmd.byte_sel)
            BSEL_DATA: shift_in = i_data_byte;
            BSEL_PAD:  shift_in = PAD_BYTE;
            BSEL_LEN:  shift_in = len_bytes[~i_cmd.len_idx];
            default:   shift_in = 8'h00;
        endcase
    end

    // window slot 0 is the oldest schedule word
    always_comb begin
        w_exp = r_win[13] ^ r_win[8] ^ r_win[2] ^ r_win[0];
        w_new = i_cmd.sched_msg ? r_win[0] : {w_exp[30:0], w_exp[31]};
        f_val = round_f(i_cmd.round_grp, r_work[1], r_work[2], r_work[3]);
        tmp   = {r_work[0][26:0], r_work[0][31:27]} + f_val + r_work[4] + w_new
              + round_k(i_cmd.round_grp);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_byte) begin
            for (int i = 0; i < 15; i++) begin
                r_win[i] <= {r_win[i][23:0], r_win[i+1][31:24]};
            end
            r_win[15] <= {r_win[15][23:0], shift_in};
        end else if (i_cmd.round_en) begin
            for (int i = 0; i < 15; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[15] <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_work) begin
            for (int i = 0; i < DIGEST_WORDS; i++) begin
                r_work[i] <= r_chain[i];
            end
        end else if (i_cmd.round_en) begin
            r_work[4] <= r_work[3];
            r_work[3] <= r_work[2];
            r_work[2] <= {r_work[1][1:0], r_work[1][31:2]};
            r_work[1] <= r_work[0];
            r_work[0] <= tmp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= IV_WORDS;
            r_count <= '0;
        end else begin
            if (i_cmd.load_iv) begin
                r_chain <= IV_WORDS;
            end else if (i_cmd.add_chain) begin
                for (int i = 0; i < DIGEST_WORDS; i++) begin
                    r_chain[i] <= r_chain[i] + r_work[i];
                end
            end
            if (i_cmd.load_iv) begin
                r_count <= '0;
            end else if (i_cmd.count_inc) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    assign o_digest_word = r_chain[i_cmd.word_idx];

endmodule

@@ rtl/sha1md_ctrl.sv @@
// ============================================================================
// SHA-1 controller
// Sequences byte intake, padding, the 80 rounds and digest output.
// ============================================================================
`include "sha1_message_digest_macros.svh"

module sha1md_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_no_data,
    input  logic                i_last_item,
    output logic                o_valid,
    input  logic                i_ready,
    output sha1md_pkg::t_dp_cmd o_cmd,
    output logic [2:0]          o_word_index,
    output logic                o_last_word
);
    import sha1md_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ROUND,
        S_ADD,
        S_OUT
    } t_state;

    localparam logic [6:0] LAST_ROUND = 7'(NUM_ROUNDS - 1);
    localparam logic [2:0] LAST_WORD  = 3'(DIGEST_WORDS - 1);

    t_state     r_state, n_state;
    logic [5:0] r_fill, n_fill;
    logic [6:0] r_round, n_round;
    logic [2:0] r_word, n_word;
    logic       r_finish, n_finish;
    logic       r_padding, n_padding;
    logic       r_pad_first, n_pad_first;
    logic       r_len_blk, n_len_blk;
    logic       in_acc;

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = (r_state == S_OUT);
    assign o_word_index = r_word;
    assign o_last_word  = (r_word == LAST_WORD);
    assign in_acc       = i_valid && o_ready;

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_round     = r_round;
        n_word      = r_word;
        n_finish    = r_finish;
        n_padding   = r_padding;
        n_pad_first = r_pad_first;
        n_len_blk   = r_len_blk;

        o_cmd           = '0;
        o_cmd.byte_sel  = BSEL_DATA;
        o_cmd.len_idx   = r_fill[2:0];
        o_cmd.word_idx  = r_word;
        o_cmd.sched_msg = (r_round < 7'd16);
        if (r_round < 7'd20) begin
            o_cmd.round_grp = 2'd0;
        end else if (r_round < 7'd40) begin
            o_cmd.round_grp = 2'd1;
        end else if (r_round < 7'd60) begin
            o_cmd.round_grp = 2'd2;
        end else begin
            o_cmd.round_grp = 2'd3;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (!i_no_data) begin
                        o_cmd.shift_byte = 1'b1;
                        o_cmd.count_inc  = 1'b1;
                        n_fill           = r_fill + 6'd1;
                    end
                    if (!i_no_data && r_fill == 6'd63) begin
                        // block full: compress first, pad afterwards if this ends it
                        o_cmd.load_work = 1'b1;
                        n_state         = S_ROUND;
                        n_finish        = i_last_item;
                    end else if (i_last_item) begin
                        n_state     = S_PAD;
                        n_padding   = 1'b1;
                        n_pad_first = 1'b1;
                    end
                end
            end
            S_PAD: begin
                o_cmd.shift_byte = 1'b1;
                if (r_pad_first) begin
                    o_cmd.byte_sel = BSEL_PAD;
                    n_len_blk      = (r_fill < 6'd56);
                end else if (r_len_blk && r_fill >= 6'd56) begin
                    o_cmd.byte_sel = BSEL_LEN;
                end else begin
                    o_cmd.byte_sel = BSEL_ZERO;
                end
                n_pad_first = 1'b0;
                n_fill      = r_fill + 6'd1;
                if (r_fill == 6'd63) begin
                    o_cmd.load_work = 1'b1;
                    n_state         = S_ROUND;
                end
            end
            S_ROUND: begin
                o_cmd.round_en = 1'b1;
                if (r_round == LAST_ROUND) begin
                    n_round = '0;
                    n_state = S_ADD;
                end else begin
                    n_round = r_round + 7'd1;
                end
            end
            S_ADD: begin
                o_cmd.add_chain = 1'b1;
                if (r_padding) begin
                    if (r_len_blk) begin
                        n_state = S_OUT;
                        n_word  = '0;
                    end else begin
                        // length did not fit: one more block of zeros and length
                        n_len_blk = 1'b1;
                        n_state   = S_PAD;
                    end
                end else if (r_finish) begin
                    n_finish    = 1'b0;
                    n_padding   = 1'b1;
                    n_pad_first = 1'b1;
                    n_state     = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    if (r_word == LAST_WORD) begin
                        o_cmd.load_iv = 1'b1;
                        n_word        = '0;
                        n_fill        = '0;
                        n_padding     = 1'b0;
                        n_len_blk     = 1'b0;
                        n_state       = S_IDLE;
                    end else begin
                        n_word = r_word + 3'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_round     <= '0;
            r_word      <= '0;
            r_finish    <= 1'b0;
            r_padding   <= 1'b0;
            r_pad_first <= 1'b0;
            r_len_blk   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_round     <= n_round;
            r_word      <= n_word;
            r_finish    <= n_finish;
            r_padding   <= n_padding;
            r_pad_first <= n_pad_first;
            r_len_blk   <= n_len_blk;
        end
    end

    `SHA1MD_ASSERT(a_ready_valid_excl, !(o_ready && o_valid), "ready and valid both high")
    `SHA1MD_ASSERT(a_last_round_adds, (r_state == S_ROUND && r_round == LAST_ROUND) |=> (r_state == S_ADD), "round 79 not followed by chain add")
    `SHA1MD_ASSERT(a_load_starts_rounds, o_cmd.load_work |=> (r_state == S_ROUND && r_round == 7'd0), "work load without round start")
    `SHA1MD_ASSERT(a_digest_end_clears, (o_valid && i_ready && o_last_word) |=> (o_ready && r_fill == 6'd0 && !r_padding), "message state not cleared after digest")

endmodule

@@ rtl/sha1_message_digest.sv @@
// ============================================================================
// SHA-1 message digest
// Byte-serial SHA-1 hash with padding and five-word digest output.
// ============================================================================
// Usage:
//   Input channel (i_valid/o_ready): one word per message byte in i_data_byte.
//   i_no_data marks a word without a byte; i_last_item ends the message
//   (with or without a byte), so an empty message is a single no-data word.
//   Output channel (o_valid/i_ready): five digest words, index 0 first,
//   o_last_word set on index 4.
// Timing:
//   A byte that does not fill a block is taken without a stall. The byte
//   that fills a 64-byte block is taken and then holds o_ready low for
//   the 80 rounds on the single round unit and the chain add. On the final
//   word, after any compression of a block it fills, the padding is shifted
//   in one byte per cycle up to the block end, followed by compression; a
//   second pad block (when fewer than 9 bytes were free) adds another pass
//   of padding and compression. Then the digest words appear, one per cycle
//   while i_ready is high; a stall just holds the current word.
// Reset:
//   Loads the initial chaining value and clears the byte count; the block
//   is ready for a new message as soon as reset is released.
module sha1_message_digest #(
    parameter int LENGTH_COUNTER_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_no_data,
    input  logic        i_last_item,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import sha1md_pkg::*;

    t_dp_cmd cmd;

    sha1md_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_no_data    (i_no_data),
        .i_last_item  (i_last_item),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_cmd        (cmd),
        .o_word_index (o_word_index),
        .o_last_word  (o_last_word)
    );

    sha1md_datapath #(
        .LENGTH_COUNTER_BITS (LENGTH_COUNTER_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_byte   (i_data_byte),
        .o_digest_word (o_digest_word)
    );

endmodule
